// ===== design/vls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the voxel line-of-sight unit.
// No dependencies; imported by the top level.
package vls_pkg;

    localparam int CELL_W = 5;
    localparam int POS_W  = 21;
    localparam int SIZE_W = 6;
    localparam int IDX_W  = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef struct packed {
        logic              command;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [CELL_W-1:0] cell_z;
        logic              occupied;
        logic [POS_W-1:0]  src_x;
        logic [POS_W-1:0]  src_y;
        logic [POS_W-1:0]  src_z;
        logic [POS_W-1:0]  dst_x;
        logic [POS_W-1:0]  dst_y;
        logic [POS_W-1:0]  dst_z;
    } in_t;

    typedef struct packed {
        logic visible;
        logic out_of_range;
    } out_t;

endpackage

// ===== design/voxel_line_of_sight_unit.sv =====
`timescale 1ns / 1ps
// Top level of the voxel line-of-sight unit: occupancy memory, ray walk sequencer.
// Depends on vls_pkg and vls_divider.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_data (in_t)
//  m_       out        m_valid / m_ready   m_data (out_t)
//  cfg_     in         cfg_wr_en           cfg_index, cfg_wr_data
//
// A write beat passes from idle through the done state. A query takes a setup step and
// then, for each voxel step, a check, a face search on the shared multiplier, a move for
// each axis with up to two of them scaled through the divider, and the memory read in
// the VOX and TEST states.
// After reset a clearing pass writes every one of the (2**clog2(MAX_SIZE))**3 memory
// rows, one per cycle; s_ready stays low during the pass.
// A result waiting on m_ready holds the sequencer in its final state; s_ready is low
// whenever the sequencer is busy.
module voxel_line_of_sight_unit
    import vls_pkg::*;
#(
    parameter int MAX_SIZE  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    localparam int LW    = $clog2(MAX_SIZE);
    localparam int AW    = 3 * LW;
    localparam int DEPTH = 1 << AW;
    localparam int PW    = ((POS_W > FRAC_BITS + LW) ? POS_W : FRAC_BITS + LW) + 2;
    localparam int VW    = PW - FRAC_BITS;
    localparam int GW    = FRAC_BITS + 1;
    localparam int PRW   = GW + POS_W;
    localparam int EW0   = $clog2(MAX_SIZE + 1);
    localparam int EW    = (EW0 > SIZE_W) ? EW0 : SIZE_W;
    localparam int CW    = (VW > EW) ? VW : EW;
    localparam int WALK_LIMIT = 8 * MAX_SIZE;
    localparam int SCW   = $clog2(WALK_LIMIT + 1);
    localparam logic signed [PW:0] HALF_T = (PW + 1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PW+1:0] HALF_G = (PW + 2)'(64'd1 << (FRAC_BITS - 1));
    localparam logic [EW-1:0] MAX_E = EW'(MAX_SIZE);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_CHECK    = 12'b000000000100,
        S_CMP_A    = 12'b000000001000,
        S_CMP_B    = 12'b000000010000,
        S_CMP_C    = 12'b000000100000,
        S_MOVE_MUL = 12'b000001000000,
        S_MOVE_DIV = 12'b000010000000,
        S_VOX      = 12'b000100000000,
        S_TEST     = 12'b001000000000,
        S_DONE     = 12'b010000000000,
        S_SPARE    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [SIZE_W-1:0]      size_x_reg, size_y_reg, size_z_reg;
    logic signed [PW-1:0]   pos_reg [3];
    logic signed [PW-1:0]   pos_next [3];
    logic [VW-1:0]          vox_reg [3];
    logic [VW-1:0]          vox_next [3];
    logic [VW-1:0]          tvox_reg [3];
    logic [VW-1:0]          tvox_next [3];
    logic [POS_W-1:0]       dst_reg [3];
    logic [POS_W-1:0]       dst_next [3];
    logic [POS_W-1:0]       mag_reg [3];
    logic [POS_W-1:0]       mag_next [3];
    logic [2:0]             neg_reg, neg_next;
    logic [GW-1:0]          gap_reg [3];
    logic [GW-1:0]          gap_next [3];
    logic [1:0]             axis_reg, axis_next;
    logic [1:0]             best_reg, best_next;
    logic                   best_vld_reg, best_vld_next;
    logic [GW-1:0]          bgap_reg, bgap_next;
    logic [POS_W-1:0]       bmag_reg, bmag_next;
    logic [PRW-1:0]         prod_a_reg, prod_a_next;
    logic [PRW-1:0]         prod_b_reg, prod_b_next;
    logic                   div_start_reg, div_start_next;
    logic [SCW-1:0]         steps_reg, steps_next;
    out_t                   res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg, m_data_next;

    logic [EW-1:0]          eff [3];
    logic [POS_W-1:0]       in_src [3];
    logic [POS_W-1:0]       in_dst [3];
    logic [VW-1:0]          src_vox [3];
    logic [VW-1:0]          dst_vox [3];
    logic                   src_in, dst_in;
    logic [VW-1:0]          walk_vox [3];
    logic                   walk_ok;
    logic signed [PW:0]     walk_t [3];
    logic signed [PW+1:0]   gap_full [3];
    logic signed [PW+1:0]   base_full [3];
    logic [GW-1:0]          mul_a;
    logic [POS_W-1:0]       mul_b;
    logic [PRW-1:0]         mul_p;
    logic                   div_done;
    logic [GW-1:0]          div_quo;
    logic [GW-1:0]          delta;
    logic [CW-1:0]          cell_cx, cell_cy, cell_cz;
    logic                   mem [DEPTH];
    logic                   mem_q;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic                   at_target;
    logic                   out_free;

    function automatic logic [VW-1:0] pt_vox(input logic [POS_W-1:0] p);
        logic [PW-1:0] t;
        t = PW'(p) + PW'(HALF_T);
        return t[PW-1:FRAC_BITS];
    endfunction

    function automatic logic vox_in(input logic [VW-1:0] v, input logic [EW-1:0] lim);
        return CW'(v) < CW'(lim);
    endfunction

    function automatic logic [AW-1:0] vox_addr(input logic [VW-1:0] x, input logic [VW-1:0] y,
                                               input logic [VW-1:0] z);
        return {x[LW-1:0], y[LW-1:0], z[LW-1:0]};
    endfunction

    vls_divider #(
        .NUM_W(PRW),
        .DEN_W(POS_W),
        .QUO_W(GW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (prod_a_reg),
        .den     (bmag_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        eff[0] = (EW'(size_x_reg) > MAX_E) ? MAX_E : EW'(size_x_reg);
        eff[1] = (EW'(size_y_reg) > MAX_E) ? MAX_E : EW'(size_y_reg);
        eff[2] = (EW'(size_z_reg) > MAX_E) ? MAX_E : EW'(size_z_reg);
        in_src[0] = s_data.src_x;
        in_src[1] = s_data.src_y;
        in_src[2] = s_data.src_z;
        in_dst[0] = s_data.dst_x;
        in_dst[1] = s_data.dst_y;
        in_dst[2] = s_data.dst_z;
        src_in = 1'b1;
        dst_in = 1'b1;
        walk_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            src_vox[i] = pt_vox(in_src[i]);
            dst_vox[i] = pt_vox(in_dst[i]);
            src_in = src_in & vox_in(src_vox[i], eff[i]);
            dst_in = dst_in & vox_in(dst_vox[i], eff[i]);
            walk_t[i] = {pos_reg[i][PW-1], pos_reg[i]} + HALF_T;
            walk_vox[i] = walk_t[i][PW-1:FRAC_BITS];
            if (walk_t[i][PW] || !vox_in(walk_vox[i], eff[i])) begin
                walk_ok = 1'b0;
            end
            base_full[i] = $signed({2'b00, vox_reg[i], {FRAC_BITS{1'b0}}});
            if (neg_reg[i]) begin
                gap_full[i] = {{2{pos_reg[i][PW-1]}}, pos_reg[i]} - base_full[i] + HALF_G;
            end else begin
                gap_full[i] = base_full[i] + HALF_G - {{2{pos_reg[i][PW-1]}}, pos_reg[i]};
            end
        end
        at_target = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (vox_reg[i] != tvox_reg[i]) begin
                at_target = 1'b0;
            end
        end
        if (pos_reg[0] == $signed(PW'(dst_reg[0])) && pos_reg[1] == $signed(PW'(dst_reg[1]))
            && pos_reg[2] == $signed(PW'(dst_reg[2]))) begin
            at_target = 1'b1;
        end
        cell_cx = CW'(s_data.cell_x);
        cell_cy = CW'(s_data.cell_y);
        cell_cz = CW'(s_data.cell_z);
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        case (state_reg)
            S_CMP_A: begin
                mul_a = gap_reg[axis_reg];
                mul_b = bmag_reg;
            end
            default: begin
                mul_a = bgap_reg;
                mul_b = mag_reg[axis_reg];
            end
        endcase
        mul_p = PRW'(mul_a) * PRW'(mul_b);
        delta = (axis_reg == best_reg) ? bgap_reg : div_quo;
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pos_next       = pos_reg;
        vox_next       = vox_reg;
        tvox_next      = tvox_reg;
        dst_next       = dst_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        gap_next       = gap_reg;
        axis_next      = axis_reg;
        best_next      = best_reg;
        best_vld_next  = best_vld_reg;
        bgap_next      = bgap_reg;
        bmag_next      = bmag_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        div_start_next = 1'b0;
        steps_next     = steps_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = 1'b0;
        mem_raddr      = vox_addr(walk_vox[0], walk_vox[1], walk_vox[2]);
        s_ready        = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_next = '0;
                    if (s_data.command == CMD_WRITE) begin
                        if (cell_cx >= CW'(MAX_SIZE) || cell_cy >= CW'(MAX_SIZE)
                            || cell_cz >= CW'(MAX_SIZE)) begin
                            res_next.out_of_range = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = {cell_cx[LW-1:0], cell_cy[LW-1:0], cell_cz[LW-1:0]};
                            mem_wdata = s_data.occupied;
                        end
                        state_next = S_DONE;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            pos_next[i]  = $signed(PW'(in_src[i]));
                            vox_next[i]  = src_vox[i];
                            tvox_next[i] = dst_vox[i];
                            dst_next[i]  = in_dst[i];
                            neg_next[i]  = in_dst[i] < in_src[i];
                            mag_next[i]  = (in_dst[i] < in_src[i]) ? in_src[i] - in_dst[i]
                                                                   : in_dst[i] - in_src[i];
                        end
                        steps_next = '0;
                        if (!src_in || !dst_in) begin
                            res_next.out_of_range = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (at_target) begin
                    res_next.visible = 1'b1;
                    state_next = S_DONE;
                end else if (steps_reg >= SCW'(WALK_LIMIT)) begin
                    res_next.out_of_range = 1'b1;
                    state_next = S_DONE;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        gap_next[i] = (gap_full[i] <= 0) ? GW'(1) : gap_full[i][GW-1:0];
                    end
                    axis_next     = 2'd0;
                    best_vld_next = 1'b0;
                    state_next    = S_CMP_A;
                end
            end
            S_CMP_A, S_CMP_C: begin
                if (state_reg == S_CMP_A && mag_reg[axis_reg] != '0 && best_vld_reg) begin
                    prod_a_next = mul_p;
                    state_next  = S_CMP_B;
                end else begin
                    if (mag_reg[axis_reg] != '0 && (!best_vld_reg || (state_reg == S_CMP_C
                        && prod_a_reg < prod_b_reg))) begin
                        best_next     = axis_reg;
                        best_vld_next = 1'b1;
                        bgap_next     = gap_reg[axis_reg];
                        bmag_next     = mag_reg[axis_reg];
                    end
                    if (axis_reg == 2'd2) begin
                        axis_next = 2'd0;
                        if (!best_vld_next) begin
                            res_next.visible = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_MOVE_MUL;
                        end
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_CMP_A;
                    end
                end
            end
            S_CMP_B: begin
                prod_b_next = mul_p;
                state_next  = S_CMP_C;
            end
            S_MOVE_MUL, S_MOVE_DIV: begin
                if (state_reg == S_MOVE_MUL && mag_reg[axis_reg] != '0
                    && axis_reg != best_reg) begin
                    prod_a_next    = mul_p;
                    div_start_next = 1'b1;
                    state_next     = S_MOVE_DIV;
                end else if (state_reg == S_MOVE_DIV && !div_done) begin
                    state_next = S_MOVE_DIV;
                end else begin
                    if (mag_reg[axis_reg] != '0) begin
                        if (neg_reg[axis_reg]) begin
                            pos_next[axis_reg] = pos_reg[axis_reg]
                                                 - $signed({{(PW - GW){1'b0}}, delta});
                        end else begin
                            pos_next[axis_reg] = pos_reg[axis_reg]
                                                 + $signed({{(PW - GW){1'b0}}, delta});
                        end
                    end
                    if (axis_reg == 2'd2) begin
                        state_next = S_VOX;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_MOVE_MUL;
                    end
                end
            end
            S_VOX: begin
                if (!walk_ok) begin
                    res_next.out_of_range = 1'b1;
                    state_next = S_DONE;
                end else begin
                    vox_next   = walk_vox;
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (!mem_q) begin
                    state_next = S_DONE;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            size_x_reg    <= SIZE_RESET;
            size_y_reg    <= SIZE_RESET;
            size_z_reg    <= SIZE_RESET;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            m_valid_reg   <= m_valid_next;
            div_start_reg <= div_start_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SIZE_X: size_x_reg <= cfg_wr_data;
                    REG_SIZE_Y: size_y_reg <= cfg_wr_data;
                    REG_SIZE_Z: size_z_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
        pos_reg      <= pos_next;
        vox_reg      <= vox_next;
        tvox_reg     <= tvox_next;
        dst_reg      <= dst_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        gap_reg      <= gap_next;
        axis_reg     <= axis_next;
        best_reg     <= best_next;
        best_vld_reg <= best_vld_next;
        bgap_reg     <= bgap_next;
        bmag_reg     <= bmag_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        steps_reg    <= steps_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/vls_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Stand-alone; used by voxel_line_of_sight_unit for the ray step scaling.
module vls_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 21,
    parameter int QUO_W = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num[NUM_W-1:QUO_W];
            quo_next  = num[QUO_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
